// ===== rtl/core/hufp_pkg.sv =====
// Shared types, protocol constants and helpers of the serial HID frame parser.
package hufp_pkg;

    // Frame header bytes.
    localparam logic [7:0] HDR_A = 8'h57;
    localparam logic [7:0] HDR_B = 8'hAB;

    // Opcodes carried in the third frame byte.
    localparam logic [7:0] OP_KEYS  = 8'h01;
    localparam logic [7:0] OP_MREL  = 8'h02;
    localparam logic [7:0] OP_MABS  = 8'h04;
    localparam logic [7:0] OP_STATE = 8'h80;
    localparam logic [7:0] OP_DISC  = 8'h86;
    localparam logic [7:0] OP_VER   = 8'h87;
    localparam logic [7:0] OP_TMO   = 8'h89;

    // State frame decoding.
    localparam logic [7:0] STATE_MASK = 8'h0F;
    localparam logic [7:0] MOUSE_BIT  = 8'h02;

    // Frame lengths and byte positions.
    localparam logic [3:0] FRAME_MAX  = 4'd11;
    localparam logic [3:0] MREL_LEN   = 4'd7;
    localparam logic [3:0] LEN_MABS   = 4'd10;
    localparam logic [3:0] LEN_STATE  = 4'd4;
    localparam logic [3:0] LEN_SHORT  = 4'd3;
    localparam logic [3:0] LEN_NONE   = 4'd0;
    localparam logic [3:0] POS_IDLE   = 4'd0;
    localparam logic [3:0] POS_HDR_B  = 4'd1;
    localparam logic [3:0] POS_OPCODE = 4'd2;
    localparam logic [3:0] POS_BYTE3  = 4'd3;
    localparam logic [3:0] POS_BYTE4  = 4'd4;
    localparam logic [3:0] POS_BYTE5  = 4'd5;
    localparam logic [3:0] POS_BYTE6  = 4'd6;

    // Statistic counter slots.
    localparam int NUM_CNT = 4;
    localparam logic [1:0] CNT_MOUSE = 2'd0;
    localparam logic [1:0] CNT_STATE = 2'd1;
    localparam logic [1:0] CNT_SYNC  = 2'd2;
    localparam logic [1:0] CNT_DISC  = 2'd3;

    // Width of the counter values reported with each result.
    localparam int OUT_CNT_W = 16;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_MOUSE = 2'd1,
        EV_LINK  = 2'd2
    } t_event_kind;

    typedef struct packed {
        t_event_kind             event_kind;
        logic [7:0]              buttons;
        logic signed [7:0]       delta_x;
        logic signed [7:0]       delta_y;
        logic signed [7:0]       wheel;
        logic                    link_changed;
        logic                    link_active;
        logic                    send_ack;
        logic [OUT_CNT_W-1:0]    mouse_report_total;
        logic [OUT_CNT_W-1:0]    state_frame_total;
        logic [OUT_CNT_W-1:0]    sync_error_total;
        logic [OUT_CNT_W-1:0]    discarded_total;
    } t_result;

    // Total frame length for an opcode; zero marks an unknown opcode.
    function automatic logic [3:0] length_of(input logic [7:0] op);
        logic [3:0] len;
        case (op)
            OP_KEYS:  len = FRAME_MAX;
            OP_MREL:  len = MREL_LEN;
            OP_MABS:  len = LEN_MABS;
            OP_STATE: len = LEN_STATE;
            OP_DISC, OP_VER, OP_TMO: len = LEN_SHORT;
            default:  len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/hufp_in_reg.sv =====
// Input register stage that holds one received byte until the parser takes it.
module hufp_in_reg
    import hufp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       accept;

    // A new request enters when the register is empty or being drained.
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== rtl/core/hufp_parser.sv =====
// Frame tracking state, link state, statistics and per-byte result decode.
module hufp_parser
    import hufp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output logic       o_has_result,
    output t_result    o_result
);

    logic [3:0]             r_held;
    logic [3:0]             r_target;
    logic [7:0]             r_op;
    logic [7:0]             r_pay [4];
    logic                   r_known;
    logic                   r_up;
    logic [COUNT_WIDTH-1:0] r_cnt [NUM_CNT];

    logic [3:0]             n_held;
    logic [3:0]             n_target;
    logic                   n_known;
    logic                   n_up;
    logic [COUNT_WIDTH-1:0] n_cnt [NUM_CNT];

    logic [3:0] len;
    logic       done;
    logic       sync_err;
    logic       store_op;
    logic       store_pay;
    logic [1:0] pay_idx;
    logic [7:0] op;
    logic [7:0] b3, b4, b5, b6;
    logic       cnt_inc [NUM_CNT];
    logic [31:0] cnt_ext [NUM_CNT];

    assign len     = length_of(i_byte);
    assign pay_idx = 2'(r_held - POS_BYTE3);

    // Payload bytes, taking the current byte when it completes the frame.
    assign b3 = (r_held == POS_BYTE3) ? i_byte : r_pay[0];
    assign b4 = (r_held == POS_BYTE4) ? i_byte : r_pay[1];
    assign b5 = (r_held == POS_BYTE5) ? i_byte : r_pay[2];
    assign b6 = (r_held == POS_BYTE6) ? i_byte : r_pay[3];
    assign op = (r_held == POS_OPCODE) ? i_byte : r_op;

    // Header hunt, opcode check and frame length tracking.
    always_comb begin
        n_held    = r_held;
        n_target  = r_target;
        done      = 1'b0;
        sync_err  = 1'b0;
        store_op  = 1'b0;
        store_pay = 1'b0;
        if (r_held == POS_IDLE) begin
            if (i_byte == HDR_A) begin
                n_held = POS_HDR_B;
            end
        end else if (r_held == POS_HDR_B) begin
            if (i_byte == HDR_B) begin
                n_held = POS_OPCODE;
            end else begin
                sync_err = 1'b1;
                n_target = LEN_NONE;
                n_held   = (i_byte == HDR_A) ? POS_HDR_B : POS_IDLE;
            end
        end else if (r_held == POS_OPCODE) begin
            if (len == LEN_NONE) begin
                sync_err = 1'b1;
                n_target = LEN_NONE;
                n_held   = (i_byte == HDR_A) ? POS_HDR_B : POS_IDLE;
            end else begin
                store_op = 1'b1;
                n_held   = POS_BYTE3;
                n_target = len;
                done     = (POS_BYTE3 >= len);
            end
        end else if (r_held < FRAME_MAX) begin
            store_pay = (r_held <= POS_BYTE6);
            n_held    = r_held + 4'd1;
            done      = (n_held >= r_target);
        end else begin
            n_target = LEN_NONE;
            n_held   = (i_byte == HDR_A) ? POS_HDR_B : POS_IDLE;
        end
        if (done) begin
            n_held   = POS_IDLE;
            n_target = LEN_NONE;
        end
    end

    // Frame interpretation: link state, event kind and counter increments.
    always_comb begin
        o_result            = '0;
        o_result.event_kind = EV_NONE;
        n_known             = r_known;
        n_up                = r_up;
        for (int i = 0; i < NUM_CNT; i++) begin
            cnt_inc[i] = 1'b0;
        end
        cnt_inc[CNT_SYNC] = sync_err;
        if (done) begin
            if (op == OP_MREL) begin
                o_result.event_kind   = EV_MOUSE;
                o_result.buttons      = b3;
                o_result.delta_x      = b4;
                o_result.delta_y      = b5;
                o_result.wheel        = b6;
                o_result.link_changed = !r_known || !r_up;
                n_known               = 1'b1;
                n_up                  = 1'b1;
                cnt_inc[CNT_MOUSE]    = 1'b1;
            end else if (op == OP_STATE) begin
                cnt_inc[CNT_STATE] = 1'b1;
                o_result.send_ack  = 1'b1;
                if (((b3 & STATE_MASK) & MOUSE_BIT) != 8'd0) begin
                    // Toggle; an unknown link comes up as connected.
                    o_result.link_changed = 1'b1;
                    o_result.event_kind   = EV_LINK;
                    n_known               = 1'b1;
                    n_up                  = r_known ? !r_up : 1'b1;
                end
            end else if (op == OP_DISC) begin
                cnt_inc[CNT_STATE] = 1'b1;
                if (!r_known || r_up) begin
                    o_result.link_changed = 1'b1;
                    o_result.event_kind   = EV_LINK;
                    n_known               = 1'b1;
                    n_up                  = 1'b0;
                end
            end else begin
                cnt_inc[CNT_DISC] = 1'b1;
            end
        end
        for (int i = 0; i < NUM_CNT; i++) begin
            n_cnt[i]   = r_cnt[i] + COUNT_WIDTH'(cnt_inc[i]);
            cnt_ext[i] = 32'(n_cnt[i]);
        end
        o_result.link_active        = n_up;
        o_result.mouse_report_total = cnt_ext[CNT_MOUSE][OUT_CNT_W-1:0];
        o_result.state_frame_total  = cnt_ext[CNT_STATE][OUT_CNT_W-1:0];
        o_result.sync_error_total   = cnt_ext[CNT_SYNC][OUT_CNT_W-1:0];
        o_result.discarded_total    = cnt_ext[CNT_DISC][OUT_CNT_W-1:0];
    end

    assign o_has_result = done;

    // Control state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= POS_IDLE;
            r_target <= LEN_NONE;
            r_known  <= 1'b0;
            r_up     <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_fire) begin
            r_held   <= n_held;
            r_target <= n_target;
            r_known  <= n_known;
            r_up     <= n_up;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    // Frame bytes that the decode reads later.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
            for (int i = 0; i < 4; i++) begin
                r_pay[i] <= '0;
            end
        end else if (i_fire) begin
            if (store_op) begin
                r_op <= i_byte;
            end
            if (store_pay) begin
                r_pay[pay_idx] <= i_byte;
            end
        end
    end

endmodule

// ===== rtl/core/hufp_out_reg.sv =====
// Result register that holds one decoded frame until the receiver takes it.
module hufp_out_reg
    import hufp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // The register can take a new result when empty or being delivered.
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/core/hid_uart_frame_parser.sv =====
// Top level of the serial HID frame parser.
//
// The input channel takes one received serial byte per request
// (i_in_valid, o_in_stall, i_rx_byte). The parser hunts for the header
// 0x57 0xAB, reads the opcode and collects the rest of the frame. Each
// completed frame gives one result request on the output channel
// (o_out_valid, i_out_stall and the decoded fields with counter values).
// Bytes that do not complete a frame give no result.
// A byte is registered at the input and decoded from that register when the
// output register can take its result; the result is loaded into the output
// register, which raises o_out_valid. One byte per cycle is sustained while
// the receiver does not stall, set by the single decode pass between the
// input and result registers.
// While the receiver stalls a held result, the input register keeps one
// byte and then stalls the sender.
// Synchronous reset clears frame tracking, the link state and all counters;
// both registers come up empty.
module hid_uart_frame_parser
    import hufp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_event_kind,
    output logic [7:0]           o_buttons,
    output logic signed [7:0]    o_delta_x,
    output logic signed [7:0]    o_delta_y,
    output logic signed [7:0]    o_wheel,
    output logic                 o_link_changed,
    output logic                 o_link_active,
    output logic                 o_send_ack,
    output logic [OUT_CNT_W-1:0] o_mouse_report_total,
    output logic [OUT_CNT_W-1:0] o_state_frame_total,
    output logic [OUT_CNT_W-1:0] o_sync_error_total,
    output logic [OUT_CNT_W-1:0] o_discarded_total
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       fire;
    logic       has_result;
    t_result    dec_result;
    t_result    out_result;

    // A held byte is decoded when the result register can take its result.
    assign fire = in_valid && out_free;

    hufp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_byte  (i_rx_byte),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .i_take  (out_free)
    );

    hufp_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte       (in_byte),
        .o_has_result (has_result),
        .o_result     (dec_result)
    );

    hufp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && has_result),
        .i_result (dec_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    // Result fields onto the output ports.
    assign o_event_kind         = out_result.event_kind;
    assign o_buttons            = out_result.buttons;
    assign o_delta_x            = out_result.delta_x;
    assign o_delta_y            = out_result.delta_y;
    assign o_wheel              = out_result.wheel;
    assign o_link_changed       = out_result.link_changed;
    assign o_link_active        = out_result.link_active;
    assign o_send_ack           = out_result.send_ack;
    assign o_mouse_report_total = out_result.mouse_report_total;
    assign o_state_frame_total  = out_result.state_frame_total;
    assign o_sync_error_total   = out_result.sync_error_total;
    assign o_discarded_total    = out_result.discarded_total;

endmodule

// ===== test/tb_hid_uart_frame_parser.sv =====
// Self-checking testbench for the serial HID frame parser, with its frame decoder scoreboard.
`timescale 1ns / 100ps

import hufp_pkg::*;

// Tracks the frame decoder state and holds the reports that accepted bytes should produce.
class hid_frame_checker;
    logic [7:0]           frame_bytes [FRAME_MAX];
    logic [3:0]           held;
    logic [3:0]           target_len;
    logic                 link_known;
    logic                 link_up;
    logic [OUT_CNT_W-1:0] mouse_total;
    logic [OUT_CNT_W-1:0] state_total;
    logic [OUT_CNT_W-1:0] sync_total;
    logic [OUT_CNT_W-1:0] discard_total;
    t_result              pending_reports [$];
    int                   mismatch_count;

    function new();
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        held = POS_IDLE;
        target_len = LEN_NONE;
        link_known = 1'b0;
        link_up = 1'b0;
        mouse_total = '0;
        state_total = '0;
        sync_total = '0;
        discard_total = '0;
        mismatch_count = 0;
    endfunction

    // Total frame length that an opcode announces; zero for an unknown opcode.
    function logic [3:0] frame_length(logic [7:0] op);
        case (op)
            OP_KEYS:                 return FRAME_MAX;
            OP_MREL:                 return MREL_LEN;
            OP_MABS:                 return LEN_MABS;
            OP_STATE:                return LEN_STATE;
            OP_DISC, OP_VER, OP_TMO: return LEN_SHORT;
            default:                 return LEN_NONE;
        endcase
    endfunction

    // Drop the partial frame; a first header byte starts a new one at once.
    function void restart_on(logic [7:0] b);
        held = POS_IDLE;
        target_len = LEN_NONE;
        if (b == HDR_A) begin
            frame_bytes[0] = b;
            held = POS_HDR_B;
        end
    endfunction

    // Move the link to a new state; returns 1 when that is a change.
    function logic link_to(logic up);
        if (link_known && link_up == up) return 1'b0;
        link_known = 1'b1;
        link_up = up;
        return 1'b1;
    endfunction

    // Notes one accepted byte. Returns 0 when the byte was ignored while hunting.
    function bit decode_byte(logic [7:0] b);
        t_result    rep;
        logic [3:0] len;
        logic [7:0] op;
        logic       changed;
        bit         consumed;

        consumed = (held != POS_IDLE) || (b == HDR_A);
        if (held == POS_IDLE) begin
            if (b == HDR_A) begin
                frame_bytes[0] = b;
                held = POS_HDR_B;
            end
            return consumed;
        end
        if (held == POS_HDR_B) begin
            if (b == HDR_B) begin
                frame_bytes[1] = b;
                held = POS_OPCODE;
            end else begin
                sync_total++;
                restart_on(b);
            end
            return consumed;
        end

        // Opcode or payload byte.
        if (held == POS_OPCODE) begin
            len = frame_length(b);
            if (len == LEN_NONE) begin
                sync_total++;
                restart_on(b);
                return consumed;
            end
            frame_bytes[POS_OPCODE] = b;
            held = POS_BYTE3;
            target_len = len;
        end else if (held < FRAME_MAX) begin
            frame_bytes[held] = b;
            held++;
        end else begin
            restart_on(b);
            return consumed;
        end
        if (held < target_len) return consumed;

        // The frame is complete: work out its report.
        op = frame_bytes[POS_OPCODE];
        held = POS_IDLE;
        target_len = LEN_NONE;
        rep = '0;
        changed = 1'b0;
        if (op == OP_MREL) begin
            rep.event_kind = EV_MOUSE;
            rep.buttons = frame_bytes[POS_BYTE3];
            rep.delta_x = frame_bytes[POS_BYTE4];
            rep.delta_y = frame_bytes[POS_BYTE5];
            rep.wheel = frame_bytes[POS_BYTE6];
            changed = link_to(1'b1);
            mouse_total++;
        end else if (op == OP_STATE) begin
            state_total++;
            rep.send_ack = 1'b1;
            // The mouse bit toggles the link; an unknown link comes up.
            if ((frame_bytes[POS_BYTE3] & STATE_MASK & MOUSE_BIT) != 8'h00) begin
                changed = link_known ? link_to(!link_up) : link_to(1'b1);
                if (changed) rep.event_kind = EV_LINK;
            end
        end else if (op == OP_DISC) begin
            state_total++;
            changed = link_to(1'b0);
            if (changed) rep.event_kind = EV_LINK;
        end else begin
            discard_total++;
        end
        rep.link_changed = changed;
        rep.link_active = link_up;
        rep.mouse_report_total = mouse_total;
        rep.state_frame_total = state_total;
        rep.sync_error_total = sync_total;
        rep.discarded_total = discard_total;
        pending_reports.push_back(rep);
        return consumed;
    endfunction

    function string report_text(t_result r);
        return $sformatf({"kind=%0d btn=%02h dx=%0d dy=%0d wh=%0d chg=%0b conn=%0b ack=%0b",
                          " cnt=%0d/%0d/%0d/%0d"},
                         r.event_kind, r.buttons, r.delta_x, r.delta_y, r.wheel,
                         r.link_changed, r.link_active, r.send_ack,
                         r.mouse_report_total, r.state_frame_total,
                         r.sync_error_total, r.discarded_total);
    endfunction

    // Compares one accepted report with the oldest one still expected.
    function void check_report(t_result got);
        t_result want;

        if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: report with none expected: %s", $realtime, report_text(got));
            return;
        end
        want = pending_reports.pop_front();
        if (got.event_kind !== want.event_kind || got.buttons !== want.buttons ||
            got.delta_x !== want.delta_x || got.delta_y !== want.delta_y ||
            got.wheel !== want.wheel || got.link_changed !== want.link_changed ||
            got.link_active !== want.link_active || got.send_ack !== want.send_ack ||
            got.mouse_report_total !== want.mouse_report_total ||
            got.state_frame_total !== want.state_frame_total ||
            got.sync_error_total !== want.sync_error_total ||
            got.discarded_total !== want.discarded_total) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: report mismatch", $realtime);
                $display("  expected %s", report_text(want));
                $display("  actual   %s", report_text(got));
            end
        end
    endfunction
endclass

module tb_hid_uart_frame_parser;

    localparam int TARGET_BYTES = 1600;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_rx_byte = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_event_kind;
    logic [7:0]           o_buttons;
    logic signed [7:0]    o_delta_x;
    logic signed [7:0]    o_delta_y;
    logic signed [7:0]    o_wheel;
    logic                 o_link_changed;
    logic                 o_link_active;
    logic                 o_send_ack;
    logic [OUT_CNT_W-1:0] o_mouse_report_total;
    logic [OUT_CNT_W-1:0] o_state_frame_total;
    logic [OUT_CNT_W-1:0] o_sync_error_total;
    logic [OUT_CNT_W-1:0] o_discarded_total;

    hid_frame_checker sb;
    t_result          seen_report;
    int               burst_left = 0;
    int               decoded_bytes = 0;
    int               quiet_cycles = 0;
    logic [9:0]       stall_phase = '0;

    hid_uart_frame_parser dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_rx_byte            (i_rx_byte),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_event_kind         (o_event_kind),
        .o_buttons            (o_buttons),
        .o_delta_x            (o_delta_x),
        .o_delta_y            (o_delta_y),
        .o_wheel              (o_wheel),
        .o_link_changed       (o_link_changed),
        .o_link_active        (o_link_active),
        .o_send_ack           (o_send_ack),
        .o_mouse_report_total (o_mouse_report_total),
        .o_state_frame_total  (o_state_frame_total),
        .o_sync_error_total   (o_sync_error_total),
        .o_discarded_total    (o_discarded_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sends one byte request; bursts of random length are mostly split by random gaps.
    task automatic push_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        if (sb.decode_byte(b)) decoded_bytes++;
    endtask

    task automatic send_header(input logic [7:0] op);
        push_byte(HDR_A);
        push_byte(HDR_B);
        push_byte(op);
    endtask

    // A well-formed frame with random payload.
    task automatic send_frame(input logic [7:0] op);
        send_header(op);
        repeat (int'(sb.frame_length(op)) - 3) push_byte(8'($urandom));
    endtask

    // Result side: check accepted reports and stall on a pattern that shifts
    // between no stalls, light and heavy random stalls, and periodic stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_report.event_kind = t_event_kind'(o_event_kind);
            seen_report.buttons = o_buttons;
            seen_report.delta_x = o_delta_x;
            seen_report.delta_y = o_delta_y;
            seen_report.wheel = o_wheel;
            seen_report.link_changed = o_link_changed;
            seen_report.link_active = o_link_active;
            seen_report.send_ack = o_send_ack;
            seen_report.mouse_report_total = o_mouse_report_total;
            seen_report.state_frame_total = o_state_frame_total;
            seen_report.sync_error_total = o_sync_error_total;
            seen_report.discarded_total = o_discarded_total;
            sb.check_report(seen_report);
        end
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0:    i_out_stall <= 1'b0;
            2'd1:    i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2:    i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_phase[3:0] < 4'd6);
        endcase
    end

    // Watchdog: too long without any accepted request ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [7:0] opcodes [7];
        int         pick;

        opcodes = '{OP_KEYS, OP_MREL, OP_MABS, OP_STATE, OP_DISC, OP_VER, OP_TMO};
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Noise before any header.
        push_byte(8'h00);
        push_byte(8'hFF);
        // State frame with the mouse bit while the link is unknown: link comes up.
        send_header(OP_STATE);
        push_byte(MOUSE_BIT);
        // Mouse report with extreme field values.
        send_header(OP_MREL);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(8'h00);
        // Disconnect, then a disconnect that changes nothing.
        send_header(OP_DISC);
        send_header(OP_DISC);
        // State frame without the mouse bit only asks for the acknowledge.
        send_header(OP_STATE);
        push_byte(8'hFD);
        // Bad second header byte that starts a new frame, then a bad opcode.
        push_byte(HDR_A);
        push_byte(HDR_A);
        push_byte(HDR_B);
        push_byte(8'h33);

        // Mostly well-formed frames, with noise and broken headers mixed in.
        while (decoded_bytes < TARGET_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                send_frame(opcodes[$urandom_range(0, 6)]);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
            end else if (pick < 94) begin
                push_byte(HDR_A);
                push_byte($urandom_range(0, 1) ? HDR_A : 8'($urandom));
            end else begin
                push_byte(HDR_A);
                push_byte(HDR_B);
                push_byte($urandom_range(0, 1) ? HDR_A : 8'($urandom));
            end
        end
        i_in_valid <= 1'b0;

        // Drain the outstanding reports, then watch for stray ones.
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
